[src/prp_pkg.sv]
`timescale 1ns / 1ps

package prp_pkg;

  localparam int IN_W   = 48;
  localparam int OUT_W  = 32;
  localparam int USER_W = 1;
  localparam int CFG_W  = 32;
  localparam int ADDR_W = 3;

  typedef enum logic [2:0] {
    REG_ZOOM    = 3'd0,
    REG_HSCALE  = 3'd1,
    REG_ANGLE_X = 3'd2,
    REG_ANGLE_Y = 3'd3,
    REG_ANGLE_Z = 3'd4,
    REG_MODE    = 3'd5,
    REG_EYE     = 3'd6,
    REG_OFFSET  = 3'd7
  } reg_idx_t;

  localparam logic [1:0] MODE_ISO   = 2'd0;
  localparam logic [1:0] MODE_ORTHO = 2'd1;
  localparam logic [1:0] MODE_PERSP = 2'd2;
  localparam logic [1:0] MODE_PAR   = 2'd3;

  localparam logic [15:0] ZOOM_RST   = 16'd5120;
  localparam logic [15:0] HSCALE_RST = 16'd256;

  localparam logic signed [34:0] CORDIC_GAIN  = 35'sd652032874;
  localparam logic [3:0]         CORDIC_LAST  = 4'd14;
  localparam logic signed [15:0] COS30_Q15    = 16'sd28378;
  localparam logic signed [41:0] COORD_LIM    = 42'sd274877906943;
  localparam logic signed [24:0] EYE_DEFAULT  = 25'sd256;

  // pipeline layout
  localparam int DIV_BITS  = 25;
  localparam int DIV_FIRST = 12;
  localparam int NSTG      = DIV_FIRST + DIV_BITS + 1;
  localparam int FINAL     = NSTG - 1;

  typedef logic signed [15:0] trig_val_t;

  typedef struct packed {
    trig_val_t sx;
    trig_val_t cx;
    trig_val_t sy;
    trig_val_t cy;
    trig_val_t sz;
    trig_val_t cz;
  } trig_t;

  function automatic logic [13:0] atan_step(input logic [3:0] i);
    logic [13:0] v;
    case (i)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      4'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

[src/prp_sincos.sv]
`timescale 1ns / 1ps

module prp_sincos (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [15:0]    angle_x,
  input  logic [15:0]    angle_y,
  input  logic [15:0]    angle_z,
  output logic           busy,
  output prp_pkg::trig_t trig
);
  import prp_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_LOAD, T_ITER, T_STORE} tstate_t;

  tstate_t            st;
  logic [1:0]         idx;
  logic [3:0]         iter;
  logic signed [34:0] x;
  logic signed [34:0] y;
  logic signed [17:0] r;
  logic               flip;

  logic [15:0]        ang;
  logic signed [17:0] a_s;
  logic signed [17:0] r_init;
  logic               flip_init;
  logic signed [34:0] xs;
  logic signed [34:0] ys;
  logic signed [17:0] at;
  logic signed [35:0] xr;
  logic signed [35:0] yr;
  logic signed [35:0] xsh;
  logic signed [35:0] ysh;
  trig_val_t          cval;
  trig_val_t          sval;

  always_comb begin
    case (idx)
      2'd0:    ang = angle_x;
      2'd1:    ang = angle_y;
      default: ang = angle_z;
    endcase
    a_s = signed'({2'b00, ang});
    if (ang >= 16'd16384 && ang < 16'd49152) begin
      r_init    = a_s - 18'sd32768;
      flip_init = 1'b1;
    end else if (ang >= 16'd49152) begin
      r_init    = a_s - 18'sd65536;
      flip_init = 1'b0;
    end else begin
      r_init    = a_s;
      flip_init = 1'b0;
    end
    xs  = x >>> iter;
    ys  = y >>> iter;
    at  = signed'({4'b0000, atan_step(iter)});
    xr  = 36'(x) + 36'sd16384;
    yr  = 36'(y) + 36'sd16384;
    xsh = xr >>> 15;
    ysh = yr >>> 15;
    if (xsh > 36'sd32767) cval = 16'sd32767;
    else if (xsh < -36'sd32767) cval = -16'sd32767;
    else cval = xsh[15:0];
    if (ysh > 36'sd32767) sval = 16'sd32767;
    else if (ysh < -36'sd32767) sval = -16'sd32767;
    else sval = ysh[15:0];
    if (flip) begin
      cval = -cval;
      sval = -sval;
    end
  end

  assign busy = (st != T_IDLE);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      st  <= T_LOAD;
      idx <= 2'd0;
    end else begin
      case (st)
        T_LOAD: begin
          x    <= CORDIC_GAIN;
          y    <= '0;
          r    <= r_init;
          flip <= flip_init;
          iter <= 4'd0;
          st   <= T_ITER;
        end
        T_ITER: begin
          if (r >= 0) begin
            x <= x - ys;
            y <= y + xs;
            r <= r - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            r <= r + at;
          end
          iter <= iter + 4'd1;
          if (iter == CORDIC_LAST) st <= T_STORE;
        end
        T_STORE: begin
          case (idx)
            2'd0: begin
              trig.cx <= cval;
              trig.sx <= sval;
            end
            2'd1: begin
              trig.cy <= cval;
              trig.sy <= sval;
            end
            default: begin
              trig.cz <= cval;
              trig.sz <= sval;
            end
          endcase
          if (idx == 2'd2) begin
            st <= T_IDLE;
          end else begin
            idx <= idx + 2'd1;
            st  <= T_LOAD;
          end
        end
        default: st <= T_IDLE;
      endcase
    end
  end

endmodule

[src/point_rotate_project.sv]
`timescale 1ns / 1ps
// throughput: one beat per cycle when the output is not stalled and the angles are
// not being recomputed, set by a 38-stage pipeline with a 25-stage restoring divider
// for perspective mode
// reset: registers take their defaults, then sine and cosine of the three
// angles are recomputed (also after any angle write), s_tready low meanwhile
module point_rotate_project (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [prp_pkg::IN_W-1:0]     s_tdata,   // map_x, map_y, map_height
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [prp_pkg::OUT_W-1:0]    m_tdata,   // screen_x, screen_y
  output logic [prp_pkg::USER_W-1:0]   m_tuser,   // out_of_range
  input  logic                         cfg_wr_en,
  input  logic [prp_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [prp_pkg::CFG_W-1:0]    cfg_wdata
);
  import prp_pkg::*;

  typedef struct packed {
    logic [62:0]        rem_x;
    logic [62:0]        rem_y;
    logic [39:0]        den;
    logic [24:0]        qx;
    logic [24:0]        qy;
    logic               sx;
    logic               sy;
    logic               ovx;
    logic               ovy;
    logic               dz;
    logic               flag_c;
    logic               flag_np;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
  } div_t;

  // configuration
  logic [15:0] zoom;
  logic [15:0] height_scale;
  logic [15:0] angle_x;
  logic [15:0] angle_y;
  logic [15:0] angle_z;
  logic [1:0]  projection_mode;
  logic [23:0] eye_dist;
  logic [31:0] screen_offset;

  logic        trig_start;
  logic        busy;
  trig_t       trig;

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom            <= ZOOM_RST;
      height_scale    <= HSCALE_RST;
      angle_x         <= '0;
      angle_y         <= '0;
      angle_z         <= '0;
      projection_mode <= MODE_ISO;
      eye_dist        <= '0;
      screen_offset   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ZOOM:    zoom            <= cfg_wdata[15:0];
        REG_HSCALE:  height_scale    <= cfg_wdata[15:0];
        REG_ANGLE_X: angle_x         <= cfg_wdata[15:0];
        REG_ANGLE_Y: angle_y         <= cfg_wdata[15:0];
        REG_ANGLE_Z: angle_z         <= cfg_wdata[15:0];
        REG_MODE:    projection_mode <= cfg_wdata[1:0];
        REG_EYE:     eye_dist        <= cfg_wdata[23:0];
        REG_OFFSET:  screen_offset   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign trig_start = cfg_wr_en && (cfg_addr == REG_ANGLE_X || cfg_addr == REG_ANGLE_Y ||
                                    cfg_addr == REG_ANGLE_Z);

  prp_sincos u_sincos (
    .clk     (clk),
    .rst     (rst),
    .start   (trig_start),
    .angle_x (angle_x),
    .angle_y (angle_y),
    .angle_z (angle_z),
    .busy    (busy),
    .trig    (trig)
  );

  logic signed [15:0] offx;
  logic signed [15:0] offy;
  logic signed [16:0] zm;
  logic signed [24:0] dsel;

  assign offx = signed'(screen_offset[15:0]);
  assign offy = signed'(screen_offset[31:16]);
  assign zm   = signed'({1'b0, zoom});
  assign dsel = (eye_dist > 24'd2) ? signed'({1'b0, eye_dist}) : EYE_DEFAULT;

  // handshake along the pipe
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;
  logic            in_acc;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || m_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign s_tready = adv[0] && !busy && !trig_start;
  assign in_acc   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_acc;
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v, input int k);
    logic signed [63:0] bias;
    bias = (64'sd1 <<< k) - 64'sd1;
    return (v + (v < 0 ? bias : 64'sd0)) >>> k;
  endfunction

  function automatic logic [16:0] sat16(input logic signed [63:0] v);
    logic [16:0] res;
    if (v > 64'sd32767) res = {1'b1, 16'h7fff};
    else if (v < -64'sd32768) res = {1'b1, 16'h8000};
    else res = {1'b0, v[15:0]};
    return res;
  endfunction

  function automatic logic [39:0] clamp_coord(input logic signed [41:0] v);
    logic [39:0] res;
    if (v > COORD_LIM) res = {1'b1, COORD_LIM[38:0]};
    else if (v < -COORD_LIM - 42'sd1) res = {1'b1, 1'b1, 38'd0};
    else res = {1'b0, v[38:0]};
    return res;
  endfunction

  function automatic div_t div_step(input div_t d, input int b);
    div_t        o;
    logic [65:0] dd;
    o  = d;
    dd = 66'(d.den) << b;
    if (66'(d.rem_x) >= dd) begin
      o.rem_x = 63'(66'(d.rem_x) - dd);
      o.qx[b] = 1'b1;
    end
    if (66'(d.rem_y) >= dd) begin
      o.rem_y = 63'(66'(d.rem_y) - dd);
      o.qy[b] = 1'b1;
    end
    return o;
  endfunction

  // stage 0: input beat
  logic signed [15:0] i_x, i_y, i_z;
  // stage 1: zoom
  logic signed [32:0] a_fx, a_fy;
  logic signed [31:0] a_p;
  // stage 2: height
  logic signed [32:0] b_fx, b_fy;
  logic signed [40:0] b_fz;
  // stage 3/4: about x
  logic signed [32:0] c_fx;
  logic signed [57:0] c_m0, c_m1, c_m2, c_m3;
  logic signed [41:0] d_fx, d_fy, d_fz;
  // stage 5/6: about y
  logic signed [41:0] e_fy;
  logic signed [57:0] e_m0, e_m1, e_m2, e_m3;
  logic signed [41:0] f_fx, f_fy, f_fz;
  // stage 7/8: about z
  logic signed [41:0] g_fz;
  logic signed [57:0] g_m0, g_m1, g_m2, g_m3;
  logic signed [41:0] h_fx, h_fy, h_fz;
  // stage 9: clamp
  logic signed [38:0] k_fx, k_fy, k_fz;
  logic               k_fl;
  // stage 10: projection terms
  logic signed [55:0] p_iax;
  logic signed [54:0] p_iay;
  logic signed [40:0] p_ox;
  logic signed [41:0] p_oy;
  logic signed [42:0] p_px, p_py;
  logic signed [63:0] p_nx, p_ny;
  logic signed [40:0] p_den;
  logic               p_fl;
  // stage 11 and divider
  div_t               d11;
  div_t               dpipe [DIV_BITS];
  // output
  logic signed [15:0] o_x, o_y;
  logic               o_fl;

  logic signed [58:0] s4_y, s4_z, s6_x, s6_z, s8_x, s8_y;
  logic [39:0]        cl_x, cl_y, cl_z;

  always_comb begin
    s4_y = (59'(c_m0) - 59'(c_m1)) >>> 15;
    s4_z = (59'(c_m2) + 59'(c_m3)) >>> 15;
    s6_x = (59'(e_m0) + 59'(e_m1)) >>> 15;
    s6_z = (59'(e_m2) - 59'(e_m3)) >>> 15;
    s8_x = (59'(g_m0) - 59'(g_m1)) >>> 15;
    s8_y = (59'(g_m2) + 59'(g_m3)) >>> 15;
    cl_x = clamp_coord(h_fx);
    cl_y = clamp_coord(h_fy);
    cl_z = clamp_coord(h_fz);
  end

  logic signed [48:0] pz;
  logic signed [39:0] iso_d;

  always_comb begin
    pz    = 49'(a_p) * 49'(zm);
    iso_d = 40'(k_fx) - 40'(k_fy);
  end

  // stage 11 combinational
  div_t               d11_next;
  logic signed [63:0] rx, ry;
  logic [16:0]        sxr, syr;
  logic [62:0]        abs_nx, abs_ny;
  logic [40:0]        abs_den;

  always_comb begin
    case (projection_mode)
      MODE_ISO: begin
        rx = trunc_shr(64'(p_iax), 23) + 64'(offx);
        ry = trunc_shr(64'(p_iay), 23) + 64'(offy);
      end
      MODE_ORTHO: begin
        rx = trunc_shr(64'(p_ox), 8);
        ry = trunc_shr(64'(p_oy), 8);
      end
      MODE_PAR: begin
        rx = trunc_shr(64'(p_px), 9);
        ry = trunc_shr(64'(p_py), 9);
      end
      default: begin
        rx = '0;
        ry = '0;
      end
    endcase
    sxr     = sat16(rx);
    syr     = sat16(ry);
    abs_nx  = p_nx[63] ? 63'(-p_nx) : p_nx[62:0];
    abs_ny  = p_ny[63] ? 63'(-p_ny) : p_ny[62:0];
    abs_den = p_den[40] ? 41'(-p_den) : p_den;

    d11_next.rem_x   = abs_nx;
    d11_next.rem_y   = abs_ny;
    d11_next.den     = abs_den[39:0];
    d11_next.qx      = '0;
    d11_next.qy      = '0;
    d11_next.sx      = p_nx[63] ^ p_den[40];
    d11_next.sy      = p_ny[63] ^ p_den[40];
    d11_next.ovx     = 65'(abs_nx) >= (65'(abs_den[39:0]) << DIV_BITS);
    d11_next.ovy     = 65'(abs_ny) >= (65'(abs_den[39:0]) << DIV_BITS);
    d11_next.dz      = (p_den == '0);
    d11_next.flag_c  = p_fl;
    d11_next.flag_np = p_fl | sxr[16] | syr[16];
    d11_next.ox      = sxr[15:0];
    d11_next.oy      = syr[15:0];
  end

  // final stage combinational
  div_t               dq;
  logic [25:0]        qmx, qmy;
  logic signed [26:0] qsx, qsy;
  logic [16:0]        fxr, fyr;
  logic signed [15:0] o_x_next, o_y_next;
  logic               o_fl_next;

  always_comb begin
    dq  = dpipe[DIV_BITS-1];
    qmx = dq.ovx ? (26'd1 << DIV_BITS) : 26'(dq.qx);
    qmy = dq.ovy ? (26'd1 << DIV_BITS) : 26'(dq.qy);
    qsx = dq.sx ? -signed'({1'b0, qmx}) : signed'({1'b0, qmx});
    qsy = dq.sy ? -signed'({1'b0, qmy}) : signed'({1'b0, qmy});
    fxr = sat16(trunc_shr(64'(qsx) + (64'(offx) <<< 8), 8));
    fyr = sat16(trunc_shr(64'(qsy) + (64'(offy) <<< 8), 8));
    if (projection_mode != MODE_PERSP) begin
      o_x_next  = dq.ox;
      o_y_next  = dq.oy;
      o_fl_next = dq.flag_np;
    end else if (dq.dz) begin
      o_x_next  = '0;
      o_y_next  = '0;
      o_fl_next = 1'b1;
    end else begin
      o_x_next  = fxr[15:0];
      o_y_next  = fyr[15:0];
      o_fl_next = dq.flag_c | fxr[16] | fyr[16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_acc) begin
      i_x <= signed'(s_tdata[15:0]);
      i_y <= signed'(s_tdata[31:16]);
      i_z <= signed'(s_tdata[47:32]);
    end
    if (adv[1]) begin
      a_fx <= 33'(i_x) * 33'(zm);
      a_fy <= 33'(i_y) * 33'(zm);
      a_p  <= 32'(i_z) * 32'(signed'(height_scale));
    end
    if (adv[2]) begin
      b_fx <= a_fx;
      b_fy <= a_fy;
      b_fz <= 41'(pz >>> 8);
    end
    if (adv[3]) begin
      c_fx <= b_fx;
      c_m0 <= 58'(b_fy) * 58'(trig.cx);
      c_m1 <= 58'(b_fz) * 58'(trig.sx);
      c_m2 <= 58'(b_fy) * 58'(trig.sx);
      c_m3 <= 58'(b_fz) * 58'(trig.cx);
    end
    if (adv[4]) begin
      d_fx <= 42'(c_fx);
      d_fy <= s4_y[41:0];
      d_fz <= s4_z[41:0];
    end
    if (adv[5]) begin
      e_fy <= d_fy;
      e_m0 <= 58'(d_fx) * 58'(trig.cy);
      e_m1 <= 58'(d_fz) * 58'(trig.sy);
      e_m2 <= 58'(d_fz) * 58'(trig.cy);
      e_m3 <= 58'(d_fx) * 58'(trig.sy);
    end
    if (adv[6]) begin
      f_fx <= s6_x[41:0];
      f_fy <= e_fy;
      f_fz <= s6_z[41:0];
    end
    if (adv[7]) begin
      g_fz <= f_fz;
      g_m0 <= 58'(f_fx) * 58'(trig.cz);
      g_m1 <= 58'(f_fy) * 58'(trig.sz);
      g_m2 <= 58'(f_fx) * 58'(trig.sz);
      g_m3 <= 58'(f_fy) * 58'(trig.cz);
    end
    if (adv[8]) begin
      h_fx <= s8_x[41:0];
      h_fy <= s8_y[41:0];
      h_fz <= g_fz;
    end
    if (adv[9]) begin
      k_fx <= cl_x[38:0];
      k_fy <= cl_y[38:0];
      k_fz <= cl_z[38:0];
      k_fl <= cl_x[39] | cl_y[39] | cl_z[39];
    end
    if (adv[10]) begin
      p_iax <= 56'(iso_d) * 56'(COS30_Q15);
      p_iay <= ((55'(k_fx) + 55'(k_fy)) <<< 14) - (55'(k_fz) <<< 15);
      p_ox  <= 41'(k_fx) + (41'(offx) <<< 8);
      p_oy  <= 42'(k_fy) - 42'(k_fz) + (42'(offy) <<< 8);
      p_px  <= (43'(k_fx) <<< 1) + 43'(k_fz) + (43'(offx) <<< 9);
      p_py  <= (43'(k_fy) <<< 1) + 43'(k_fz) + (43'(offy) <<< 9);
      p_nx  <= 64'(k_fx) * 64'(dsel);
      p_ny  <= 64'(k_fy) * 64'(dsel);
      p_den <= 41'(dsel) + 41'(k_fz);
      p_fl  <= k_fl;
    end
    if (adv[11]) d11 <= d11_next;
    if (adv[DIV_FIRST]) dpipe[0] <= div_step(d11, DIV_BITS - 1);
    for (int k = 1; k < DIV_BITS; k++) begin
      if (adv[DIV_FIRST+k]) dpipe[k] <= div_step(dpipe[k-1], DIV_BITS - 1 - k);
    end
    if (adv[FINAL]) begin
      o_x  <= o_x_next;
      o_y  <= o_y_next;
      o_fl <= o_fl_next;
    end
  end

  assign m_tvalid = vld[FINAL];
  assign m_tdata  = {o_y, o_x};
  assign m_tuser  = o_fl;

endmodule
